FILE: hdl/izs_pkg.sv
package izs_pkg;

    // Default and storage size of the zone table.
    localparam int MAX_ZONES_DEF = 8;
    localparam int ZONE_SLOTS    = 8;
    localparam int DAY_BITS      = 7;
    localparam int MINUTE_BITS   = 8;

    // Widths of the stream payloads.
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Fixed values of the sequencer.
    localparam logic [3:0]  PHASE_OFF    = 4'd9;
    localparam logic [3:0]  NO_WDAY      = 4'd15;
    localparam logic [20:0] NO_DAY       = 21'h1FFFFF;
    localparam logic [3:0]  WEEKDAY_MAX  = 4'd6;
    localparam logic [16:0] SECS_PER_MIN = 17'd60;

    // Event flags in the result.
    localparam logic [5:0] EV_START    = 6'b000001;
    localparam logic [5:0] EV_RAINSKIP = 6'b000010;
    localparam logic [5:0] EV_RAINSTOP = 6'b000100;
    localparam logic [5:0] EV_DONE     = 6'b001000;
    localparam logic [5:0] EV_MANUAL   = 6'b010000;
    localparam logic [5:0] EV_PUMP     = 6'b100000;

    // Kind of an input item.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ZONE_COUNT    = 3'd0,
        REG_START_MINUTE  = 3'd1,
        REG_REPEAT_LIMIT  = 3'd2,
        REG_OFF_MINUTES   = 3'd3,
        REG_ZONE_MINUTES  = 3'd4,
        REG_ZONE_DAYS     = 3'd5,
        REG_VALVE_PRESENT = 3'd6,
        REG_PUMP_PRESENT  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0]  zone_count;
        logic [10:0] start_minute;
        logic [7:0]  repeat_limit;
        logic [10:0] off_minutes;
        logic [ZONE_SLOTS*MINUTE_BITS-1:0] zone_minutes;
        logic [ZONE_SLOTS*DAY_BITS-1:0]    zone_days;
        logic [ZONE_SLOTS-1:0]             valve_present;
        logic        pump_present;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] minute_of_day;
        logic [19:0] day_code;
        logic [2:0]  weekday;
        logic [31:0] now_seconds;
        logic        rain_valid;
        logic        rain;
    } item_t;

    typedef struct packed {
        logic [3:0]  zone_index;
        logic [16:0] phase_seconds;
        logic [31:0] phase_started;
        logic [7:0]  pass_count;
        logic [20:0] last_run_day;
        logic [3:0]  run_weekday;
        logic        pump_state;
        logic [3:0]  valve_state;
    } state_t;

    typedef struct packed {
        logic        pump_on;
        logic [3:0]  open_zone;
        logic [3:0]  phase_zone;
        logic [7:0]  repeats_done;
        logic [5:0]  events;
    } result_t;

endpackage

FILE: hdl/izs_cfg_regs.sv
module izs_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output izs_pkg::cfg_t       cfg
);

    izs_pkg::cfg_t cfg_reg;
    izs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode a register write; each register keeps only its own width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (izs_pkg::cfg_reg_t'(cfg_index))
                izs_pkg::REG_ZONE_COUNT:    cfg_next.zone_count    = cfg_data[3:0];
                izs_pkg::REG_START_MINUTE:  cfg_next.start_minute  = cfg_data[10:0];
                izs_pkg::REG_REPEAT_LIMIT:  cfg_next.repeat_limit  = cfg_data[7:0];
                izs_pkg::REG_OFF_MINUTES:   cfg_next.off_minutes   = cfg_data[10:0];
                izs_pkg::REG_ZONE_MINUTES:
                    cfg_next.zone_minutes =
                        cfg_data[izs_pkg::ZONE_SLOTS*izs_pkg::MINUTE_BITS-1:0];
                izs_pkg::REG_ZONE_DAYS:
                    cfg_next.zone_days =
                        cfg_data[izs_pkg::ZONE_SLOTS*izs_pkg::DAY_BITS-1:0];
                izs_pkg::REG_VALVE_PRESENT:
                    cfg_next.valve_present = cfg_data[izs_pkg::ZONE_SLOTS-1:0];
                izs_pkg::REG_PUMP_PRESENT:  cfg_next.pump_present  = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/izs_step.sv
module izs_step #(
    parameter int MAX_ZONES = izs_pkg::MAX_ZONES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  izs_pkg::cfg_t     cfg,
    input  izs_pkg::item_t    item,
    output izs_pkg::result_t  result
);

    typedef struct packed {
        izs_pkg::state_t st;
        logic [5:0]      ev;
    } work_t;

    // State after reset: idle, no run day and no run weekday recorded.
    localparam izs_pkg::state_t STATE_INIT = '{
        zone_index:    4'd0,
        phase_seconds: 17'd0,
        phase_started: 32'd0,
        pass_count:    8'd0,
        last_run_day:  izs_pkg::NO_DAY,
        run_weekday:   izs_pkg::NO_WDAY,
        pump_state:    1'b0,
        valve_state:   4'd0
    };

    izs_pkg::state_t state_reg;
    izs_pkg::state_t state_next;
    logic [3:0]      eff_count;

    // Zone count saturated to the number of zones built.
    assign eff_count = (cfg.zone_count > 4'(MAX_ZONES)) ? 4'(MAX_ZONES) : cfg.zone_count;

    function automatic logic zone_allowed(logic [3:0] z, logic [3:0] wd);
        logic [izs_pkg::DAY_BITS-1:0] mask;
        mask = '0;
        for (int i = 0; i < MAX_ZONES; i++)
        begin
            if (z == 4'(i + 1))
            begin
                mask = cfg.zone_days[i*izs_pkg::DAY_BITS +: izs_pkg::DAY_BITS];
            end
        end
        return (wd <= izs_pkg::WEEKDAY_MAX) ? mask[wd[2:0]] : 1'b0;
    endfunction

    function automatic logic [16:0] zone_secs(logic [3:0] z);
        logic [izs_pkg::MINUTE_BITS-1:0] mins;
        mins = '0;
        for (int i = 0; i < MAX_ZONES; i++)
        begin
            if (z == 4'(i + 1))
            begin
                mins = cfg.zone_minutes[i*izs_pkg::MINUTE_BITS +: izs_pkg::MINUTE_BITS];
            end
        end
        return 17'(mins) * izs_pkg::SECS_PER_MIN;
    endfunction

    function automatic logic has_valve(logic [3:0] z);
        logic v;
        v = 1'b0;
        for (int i = 0; i < MAX_ZONES; i++)
        begin
            if (z == 4'(i + 1))
            begin
                v = cfg.valve_present[i];
            end
        end
        return v;
    endfunction

    // True when at least one counted zone may run on the weekday.
    function automatic logic any_zone_today(logic [3:0] wd);
        logic any;
        any = 1'b0;
        for (int i = 0; i < MAX_ZONES; i++)
        begin
            if ((4'(i) < eff_count) && zone_allowed(4'(i + 1), wd))
            begin
                any = 1'b1;
            end
        end
        return any;
    endfunction

    function automatic work_t pump_set(work_t w, logic on);
        work_t r;
        r = w;
        if (on)
        begin
            if (cfg.pump_present && !r.st.pump_state)
            begin
                r.st.pump_state = 1'b1;
                r.ev = r.ev | izs_pkg::EV_PUMP;
            end
        end
        else if (r.st.pump_state)
        begin
            r.st.pump_state = 1'b0;
            r.ev = r.ev | izs_pkg::EV_PUMP;
        end
        return r;
    endfunction

    function automatic work_t run_start(work_t w, logic [3:0] wd, logic [19:0] day,
                                        logic [31:0] now);
        work_t r;
        r = w;
        if (any_zone_today(wd))
        begin
            r.ev = r.ev | izs_pkg::EV_START;
            r = pump_set(r, 1'b1);
            r.st.valve_state   = '0;
            r.st.last_run_day  = {1'b0, day};
            r.st.phase_started = now;
            r.st.pass_count    = '0;
            r.st.run_weekday   = wd;
            r.st.zone_index    = 4'd1;
            r.st.phase_seconds = zone_allowed(4'd1, wd) ? zone_secs(4'd1) : '0;
        end
        return r;
    endfunction

    function automatic work_t run_stop(work_t w, logic [5:0] flag);
        work_t r;
        r = w;
        if (r.st.zone_index != '0)
        begin
            r.ev = r.ev | flag;
        end
        r.st.valve_state   = '0;
        r.st.pass_count    = '0;
        r.st.zone_index    = '0;
        r.st.phase_seconds = '0;
        r.st.run_weekday   = izs_pkg::NO_WDAY;
        r = pump_set(r, 1'b0);
        return r;
    endfunction

    function automatic work_t next_zone(work_t w, logic [3:0] wd, logic [31:0] now,
                                        logic pump_off);
        work_t r;
        r = w;
        r.st.valve_state   = '0;
        r.st.phase_started = now;
        r.st.zone_index    = r.st.zone_index + 4'd1;
        if (r.st.zone_index > eff_count)
        begin
            if (pump_off)
            begin
                r = pump_set(r, 1'b0);
            end
            r.st.phase_seconds = 17'(cfg.off_minutes) * izs_pkg::SECS_PER_MIN;
        end
        else
        begin
            r.st.phase_seconds = zone_allowed(r.st.zone_index, wd) ?
                                 zone_secs(r.st.zone_index) : '0;
        end
        return r;
    endfunction

    // One step of the sequencer for the item at the input register.
    always_comb
    begin
        work_t       w;
        logic [3:0]  wd_in;
        logic [3:0]  wd;
        logic        rainy;
        logic        today;
        logic [31:0] elapsed;

        w.st    = state_reg;
        w.ev    = '0;
        wd_in   = {1'b0, item.weekday};
        rainy   = item.rain_valid && item.rain;
        today   = any_zone_today(wd_in);
        wd      = (state_reg.run_weekday != izs_pkg::NO_WDAY) ? state_reg.run_weekday : wd_in;
        elapsed = '0;

        case (item.kind)
            izs_pkg::KIND_TICK:
            begin
                if (today || (state_reg.run_weekday != izs_pkg::NO_WDAY))
                begin
                    // Daily start, or a rain skip, or a rain stop of a running pass.
                    if ((w.st.zone_index == '0) && (w.st.last_run_day != {1'b0, item.day_code})
                        && (item.minute_of_day >= cfg.start_minute))
                    begin
                        if (!rainy)
                        begin
                            w = run_start(w, wd_in, item.day_code, item.now_seconds);
                        end
                        else
                        begin
                            w.st.last_run_day = {1'b0, item.day_code};
                            w.ev = w.ev | izs_pkg::EV_RAINSKIP;
                        end
                    end
                    else if (rainy && (w.st.zone_index != '0))
                    begin
                        w = run_stop(w, izs_pkg::EV_RAINSTOP);
                    end

                    // Advance the running phase.
                    if (w.st.zone_index != '0)
                    begin
                        elapsed = item.now_seconds - w.st.phase_started;
                        if (w.st.zone_index <= eff_count)
                        begin
                            if (has_valve(w.st.zone_index))
                            begin
                                if (elapsed < 32'(w.st.phase_seconds))
                                begin
                                    w = pump_set(w, 1'b1);
                                    w.st.valve_state = w.st.zone_index;
                                end
                                else
                                begin
                                    w = next_zone(w, wd, item.now_seconds, 1'b1);
                                end
                            end
                            else
                            begin
                                w = next_zone(w, wd, item.now_seconds, 1'b0);
                            end
                        end
                        else
                        begin
                            // Off-time wait after the last zone.
                            w = pump_set(w, 1'b0);
                            if (w.st.pass_count >= cfg.repeat_limit)
                            begin
                                w = run_stop(w, izs_pkg::EV_DONE);
                            end
                            else if (elapsed > 32'(w.st.phase_seconds))
                            begin
                                w.st.pass_count    = w.st.pass_count + 8'd1;
                                w.st.phase_started = item.now_seconds;
                                w.st.zone_index    = 4'd1;
                                w.st.phase_seconds = zone_secs(4'd1);
                            end
                        end
                    end
                end
            end
            izs_pkg::KIND_START:
            begin
                w = run_start(w, wd_in, item.day_code, item.now_seconds);
            end
            izs_pkg::KIND_STOP:
            begin
                w = run_stop(w, izs_pkg::EV_MANUAL);
            end
            default:
            begin
                w.st = state_reg;
            end
        endcase

        state_next          = w.st;
        result.pump_on      = w.st.pump_state & cfg.pump_present;
        result.open_zone    = w.st.valve_state;
        result.phase_zone   = (w.st.zone_index > eff_count) ? izs_pkg::PHASE_OFF
                                                            : w.st.zone_index;
        result.repeats_done = w.st.pass_count;
        result.events       = w.ev;
    end

    // Sequencer state, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_INIT;
        end
        else if (en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/irrigation_zone_sequencer_unit.sv
// Irrigation zone sequencer: every tick, start or stop command that arrives on the
// input stream produces exactly one status word on the output stream (pump, open
// valve, current phase, repeat count and event flags), reflecting the state after
// that item. One item is taken per clock cycle unless the output stalls; an item
// is held first in the input register and then in the result register,
// with the whole step evaluated by the logic between them. The input side keeps
// accepting while a finished result waits, as long as the result register is being
// emptied. Configuration writes complete in the cycle they are presented and should
// be made while no item is in flight. There is no memory and no start-up sweep.
module irrigation_zone_sequencer_unit #(
    parameter int MAX_ZONES = izs_pkg::MAX_ZONES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // minute_of_day[10:0], day_code[30:11], weekday[33:31], now_seconds[65:34],
    // rain_valid[66], rain[67], zero fill above
    input  logic [izs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [izs_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pump_on[0], open_zone[4:1], phase_zone[8:5], repeats_done[16:9],
    // events[22:17], zero fill above
    output logic [izs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [63:0]                     cfg_data
);

    izs_pkg::cfg_t    cfg;
    izs_pkg::item_t   item_reg;
    izs_pkg::result_t step_result;
    izs_pkg::result_t out_reg;
    logic             in_vld_reg;
    logic             in_vld_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic             advance;
    logic             in_xfer;

    izs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    izs_step #(
        .MAX_ZONES (MAX_ZONES)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .cfg    (cfg),
        .item   (item_reg),
        .result (step_result)
    );

    // The held item moves on whenever the result register is free or being emptied.
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_xfer)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: input item on a transfer in, result on advance.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.kind          <= izs_pkg::kind_t'(s_axis_tuser[1:0]);
            item_reg.minute_of_day <= s_axis_tdata[10:0];
            item_reg.day_code      <= s_axis_tdata[30:11];
            item_reg.weekday       <= s_axis_tdata[33:31];
            item_reg.now_seconds   <= s_axis_tdata[65:34];
            item_reg.rain_valid    <= s_axis_tdata[66];
            item_reg.rain          <= s_axis_tdata[67];
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_reg.events, out_reg.repeats_done, out_reg.phase_zone,
                            out_reg.open_zone, out_reg.pump_on};

endmodule

FILE: hdl/izs_checker.sv
module izs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [izs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // With the result register empty the input side must be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

    // Start, rain skip, rain stop, finish and manual stop never share one step.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[21:17]))
    else $error("conflicting run events in one result");

    // A manual stop leaves the system idle with valves closed and count cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[21] |->
            (m_axis_tdata[8:1] == 8'd0) && (m_axis_tdata[16:9] == 8'd0))
    else $error("manual stop left the run active");

endmodule

bind irrigation_zone_sequencer_unit izs_checker u_izs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/irrigation_zone_sequencer_unit_test.sv
`timescale 1ns / 100ps

module irrigation_zone_sequencer_unit_test;

    localparam int          ZONES          = izs_pkg::MAX_ZONES_DEF;
    localparam int          HOLD_CYCLES    = 60;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;
    localparam int unsigned DAY_SECONDS    = 86400;

    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [izs_pkg::IN_DATA_W-1:0]       s_axis_tdata  = '0;
    logic [izs_pkg::IN_USER_W-1:0]       s_axis_tuser  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [izs_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [2:0]                          cfg_index     = '0;
    logic [63:0]                         cfg_data      = '0;

    // Items waiting to be sent and status words still owed by the block.
    izs_pkg::item_t   schedule_inputs[$];
    izs_pkg::result_t status_due[$];

    int errors        = 0;
    int quiet_cycles  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int send_gap      = 0;
    bit idle_on       = 1'b1;
    bit in_taken      = 1'b0;

    // Simulated wall clock used to build realistic tick sequences.
    logic [31:0] wall_clock;
    logic [19:0] calendar_day;
    int unsigned week_pos;
    int unsigned sec_of_day;

    // Predicted sequencer state and its copy of the settings.
    izs_pkg::cfg_t zone_plan;
    logic [3:0]    run_zone;
    logic [31:0]   phase_len;
    logic [31:0]   phase_t0;
    logic [7:0]    passes;
    logic [20:0]   ran_day;
    logic [3:0]    run_wday;
    logic          pump_st;
    logic [3:0]    valve_open;
    logic [5:0]    step_events;

    irrigation_zone_sequencer_unit #(
        .MAX_ZONES (ZONES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Schedule predictor
    // ------------------------------------------------------------------

    function automatic void clear_schedule();
        zone_plan  = '0;
        run_zone   = '0;
        phase_len  = '0;
        phase_t0   = '0;
        passes     = '0;
        ran_day    = izs_pkg::NO_DAY;
        run_wday   = izs_pkg::NO_WDAY;
        pump_st    = 1'b0;
        valve_open = '0;
    endfunction

    function automatic void store_register(logic [2:0] idx, logic [63:0] value);
        case (izs_pkg::cfg_reg_t'(idx))
            izs_pkg::REG_ZONE_COUNT:    zone_plan.zone_count    = value[3:0];
            izs_pkg::REG_START_MINUTE:  zone_plan.start_minute  = value[10:0];
            izs_pkg::REG_REPEAT_LIMIT:  zone_plan.repeat_limit  = value[7:0];
            izs_pkg::REG_OFF_MINUTES:   zone_plan.off_minutes   = value[10:0];
            izs_pkg::REG_ZONE_MINUTES:  zone_plan.zone_minutes  = value;
            izs_pkg::REG_ZONE_DAYS:     zone_plan.zone_days     = value[55:0];
            izs_pkg::REG_VALVE_PRESENT: zone_plan.valve_present = value[7:0];
            izs_pkg::REG_PUMP_PRESENT:  zone_plan.pump_present  = value[0];
            default: ;
        endcase
    endfunction

    // An oversized zone count saturates at the table size.
    function automatic int unsigned zones_in_use();
        return (zone_plan.zone_count > ZONES) ? ZONES : zone_plan.zone_count;
    endfunction

    function automatic bit zone_on_day(int unsigned z, int unsigned wd);
        if (z < 1 || z > ZONES || wd > izs_pkg::WEEKDAY_MAX)
            return 1'b0;
        return zone_plan.zone_days[izs_pkg::DAY_BITS * (z - 1) + wd];
    endfunction

    function automatic int unsigned zone_secs(int unsigned z);
        if (z < 1 || z > ZONES)
            return 0;
        return izs_pkg::SECS_PER_MIN *
               zone_plan.zone_minutes[izs_pkg::MINUTE_BITS * (z - 1) +: izs_pkg::MINUTE_BITS];
    endfunction

    function automatic bit valve_fitted(int unsigned z);
        if (z < 1 || z > ZONES)
            return 1'b0;
        return zone_plan.valve_present[z - 1];
    endfunction

    function automatic int unsigned allowed_today(int unsigned wd);
        int unsigned cnt;
        cnt = 0;
        for (int unsigned z = 1; z <= zones_in_use(); z++)
            if (zone_on_day(z, wd))
                cnt++;
        return cnt;
    endfunction

    // Switching on needs a pump; switching off always clears the output.
    function automatic void set_pump(bit on);
        if (on)
        begin
            if (zone_plan.pump_present && !pump_st)
            begin
                pump_st = 1'b1;
                step_events |= izs_pkg::EV_PUMP;
            end
        end
        else if (pump_st)
        begin
            pump_st = 1'b0;
            step_events |= izs_pkg::EV_PUMP;
        end
    endfunction

    function automatic void begin_run(int unsigned wd, logic [19:0] day, logic [31:0] now);
        if (allowed_today(wd) == 0)
            return;
        step_events |= izs_pkg::EV_START;
        set_pump(1'b1);
        valve_open = '0;
        ran_day    = {1'b0, day};
        phase_t0   = now;
        passes     = '0;
        run_wday   = 4'(wd);
        run_zone   = 4'd1;
        phase_len  = zone_on_day(1, wd) ? zone_secs(1) : 0;
    endfunction

    function automatic void end_run(logic [5:0] flag);
        if (run_zone > 0)
            step_events |= flag;
        valve_open = '0;
        passes     = '0;
        run_zone   = '0;
        phase_len  = '0;
        run_wday   = izs_pkg::NO_WDAY;
        set_pump(1'b0);
    endfunction

    // Past the last zone the phase becomes the off-time wait.
    function automatic void next_zone(int unsigned wd, logic [31:0] now, bit pump_off);
        valve_open = '0;
        phase_t0   = now;
        run_zone   = run_zone + 4'd1;
        if (run_zone > zones_in_use())
        begin
            if (pump_off)
                set_pump(1'b0);
            phase_len = izs_pkg::SECS_PER_MIN * zone_plan.off_minutes;
        end
        else
        begin
            phase_len = zone_on_day(run_zone, wd) ? zone_secs(run_zone) : 0;
        end
    endfunction

    function automatic void on_tick(izs_pkg::item_t it);
        int unsigned wd;
        int unsigned n;
        logic [31:0] elapsed;
        bit          rainy;
        n     = zones_in_use();
        rainy = it.rain_valid && it.rain;
        if (allowed_today(it.weekday) == 0 && run_wday == izs_pkg::NO_WDAY)
            return;
        wd = (run_wday != izs_pkg::NO_WDAY) ? run_wday : it.weekday;

        // Daily start, or skip of the day on rain; rain also stops a run.
        if (run_zone == 0 && ran_day != {1'b0, it.day_code}
            && it.minute_of_day >= zone_plan.start_minute)
        begin
            if (!rainy)
                begin_run(it.weekday, it.day_code, it.now_seconds);
            else
            begin
                ran_day = {1'b0, it.day_code};
                step_events |= izs_pkg::EV_RAINSKIP;
            end
        end
        else if (rainy && run_zone > 0)
        begin
            end_run(izs_pkg::EV_RAINSTOP);
        end

        if (run_zone == 0)
            return;
        elapsed = it.now_seconds - phase_t0;
        if (run_zone <= n)
        begin
            if (valve_fitted(run_zone))
            begin
                if (elapsed < phase_len)
                begin
                    set_pump(1'b1);
                    valve_open = run_zone;
                end
                else
                begin
                    next_zone(wd, it.now_seconds, 1'b1);
                end
            end
            else
            begin
                next_zone(wd, it.now_seconds, 1'b0);
            end
        end
        else
        begin
            // Off-time wait: finish, or start another pass once it has passed.
            set_pump(1'b0);
            if (passes >= zone_plan.repeat_limit)
                end_run(izs_pkg::EV_DONE);
            else if (elapsed > phase_len)
            begin
                passes    = passes + 8'd1;
                phase_t0  = it.now_seconds;
                run_zone  = 4'd1;
                phase_len = zone_secs(1);
            end
        end
    endfunction

    function automatic izs_pkg::result_t advance_schedule(izs_pkg::item_t it);
        izs_pkg::result_t r;
        step_events = '0;
        case (it.kind)
            izs_pkg::KIND_TICK:  on_tick(it);
            izs_pkg::KIND_START: begin_run(it.weekday, it.day_code, it.now_seconds);
            izs_pkg::KIND_STOP:  end_run(izs_pkg::EV_MANUAL);
            default: ;
        endcase
        r.pump_on      = pump_st & zone_plan.pump_present;
        r.open_zone    = valve_open;
        r.phase_zone   = (run_zone > zones_in_use()) ? izs_pkg::PHASE_OFF : run_zone;
        r.repeats_done = passes;
        r.events       = step_events;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void enqueue_item(logic [1:0] k, int unsigned minute, int unsigned day,
                                         int unsigned wd, logic [31:0] now, bit rv, bit rn);
        izs_pkg::item_t it;
        it.kind          = izs_pkg::kind_t'(k);
        it.minute_of_day = 11'(minute);
        it.day_code      = 20'(day);
        it.weekday       = 3'(wd);
        it.now_seconds   = now;
        it.rain_valid    = rv;
        it.rain          = rn;
        schedule_inputs.push_back(it);
    endfunction

    // A new day begins a little before the start time.
    function automatic void roll_to_next_day(int unsigned start_at);
        int unsigned lead;
        lead         = $urandom_range(0, 180);
        calendar_day = calendar_day + 20'd1;
        week_pos     = (week_pos + 1) % 7;
        sec_of_day   = (start_at * 60 > lead) ? start_at * 60 - lead : 0;
    endfunction

    function automatic logic [63:0] short_durations(int unsigned longest);
        logic [63:0] v;
        for (int z = 0; z < ZONES; z++)
            v[izs_pkg::MINUTE_BITS * z +: izs_pkg::MINUTE_BITS] = 8'($urandom_range(0, longest));
        return v;
    endfunction

    // Mostly ordered ticks over days, with commands and random noise mixed in.
    function automatic void queue_run_traffic(int count, int unsigned start_at);
        int unsigned pick;
        int unsigned step;
        wall_clock   = $urandom();
        calendar_day = 20'($urandom_range(0, 20'hFFFF0));
        week_pos     = $urandom_range(0, 6);
        roll_to_next_day(start_at);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                enqueue_item(2'($urandom_range(0, 3)), $urandom_range(0, 2047),
                             $urandom_range(0, 20'hFFFFF), $urandom_range(0, 7), $urandom(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (pick < 9)
                enqueue_item(izs_pkg::KIND_START, sec_of_day / 60, calendar_day, week_pos,
                             wall_clock, 1'b0, 1'b0);
            else if (pick < 12)
                enqueue_item(izs_pkg::KIND_STOP, sec_of_day / 60, calendar_day, week_pos,
                             wall_clock, 1'b0, 1'b0);
            else if (pick < 13)
                enqueue_item(KIND_UNUSED, sec_of_day / 60, calendar_day, week_pos, wall_clock,
                             1'b0, 1'b0);
            else
            begin
                if (pick < 20)
                    roll_to_next_day(start_at);
                else
                begin
                    step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000)
                                                       : $urandom_range(0, 90);
                    wall_clock = wall_clock + step;
                    sec_of_day = sec_of_day + step;
                    if (sec_of_day >= DAY_SECONDS)
                        roll_to_next_day(start_at);
                end
                enqueue_item(izs_pkg::KIND_TICK, sec_of_day / 60, calendar_day, week_pos,
                             wall_clock, 1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
            end
        end
    endfunction

    task automatic write_register(input izs_pkg::cfg_reg_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_plan(input logic [3:0] zone_cnt, input logic [10:0] start_at,
                                input logic [7:0] repeats, input logic [10:0] off_min,
                                input logic [63:0] minutes, input logic [55:0] days,
                                input logic [7:0] valves, input logic pump);
        write_register(izs_pkg::REG_ZONE_COUNT, 64'(zone_cnt));
        write_register(izs_pkg::REG_START_MINUTE, 64'(start_at));
        write_register(izs_pkg::REG_REPEAT_LIMIT, 64'(repeats));
        write_register(izs_pkg::REG_OFF_MINUTES, 64'(off_min));
        write_register(izs_pkg::REG_ZONE_MINUTES, minutes);
        write_register(izs_pkg::REG_ZONE_DAYS, 64'(days));
        write_register(izs_pkg::REG_VALVE_PRESENT, 64'(valves));
        write_register(izs_pkg::REG_PUMP_PRESENT, 64'(pump));
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Returns at a rising edge once nothing is queued, offered or owed.
    task automatic wait_quiet();
        do @(posedge clk);
        while (schedule_inputs.size() != 0 || s_axis_tvalid || status_due.size() != 0);
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: presents one item per transfer, with random gaps.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : feed_driver
        izs_pkg::item_t nxt;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (schedule_inputs.size() != 0)
            begin
                nxt = schedule_inputs.pop_front();
                s_axis_tdata  <= {4'b0, nxt.rain, nxt.rain_valid, nxt.now_seconds,
                                  nxt.weekday, nxt.day_code, nxt.minute_of_day};
                s_axis_tuser  <= nxt.kind;
                s_axis_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 18);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: random stall bursts plus the requested long hold-off.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each status transfer, predicts each input transfer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : status_monitor
        izs_pkg::item_t   seen;
        izs_pkg::result_t want;
        bit               moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                store_register(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (status_due.size() == 0)
                begin
                    $display("%0t: status transfer with nothing expected, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("pump_on", want.pump_on, m_axis_tdata[0]);
                    check_field("open_zone", want.open_zone, m_axis_tdata[4:1]);
                    check_field("phase_zone", want.phase_zone, m_axis_tdata[8:5]);
                    check_field("repeats_done", want.repeats_done, m_axis_tdata[16:9]);
                    check_field("events", want.events, m_axis_tdata[22:17]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved              = 1'b1;
                seen.kind          = izs_pkg::kind_t'(s_axis_tuser);
                seen.minute_of_day = s_axis_tdata[10:0];
                seen.day_code      = s_axis_tdata[30:11];
                seen.weekday       = s_axis_tdata[33:31];
                seen.now_seconds   = s_axis_tdata[65:34];
                seen.rain_valid    = s_axis_tdata[66];
                seen.rain          = s_axis_tdata[67];
                status_due.push_back(advance_schedule(seen));
            end
            in_taken <= s_axis_tvalid && s_axis_tready;

            // Watchdog on cycles without any transfer.
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned start_at;
        clear_schedule();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset settings no zone exists, so nothing may happen.
        enqueue_item(izs_pkg::KIND_TICK, 0, 0, 0, 32'd0, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_START, 0, 0, 0, 32'd0, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_STOP, 0, 0, 0, 32'd0, 1'b0, 1'b0);
        wait_quiet();

        // Three zones: the second runs on weekday 0 only and has no valve.
        program_plan(4'd3, 11'd600, 8'd1, 11'd1, 64'h0000_0000_0001_0201,
                     56'h1F_C0FF, 8'b0000_0101, 1'b1);
        enqueue_item(izs_pkg::KIND_TICK, 599, 5, 0, 32'd100, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 600, 5, 0, 32'd110, 1'b1, 1'b1);
        enqueue_item(izs_pkg::KIND_TICK, 700, 5, 0, 32'd120, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 600, 6, 1, 32'hFFFF_FFF0, 1'b1, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 601, 6, 1, 32'h0000_0020, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 601, 6, 1, 32'h0000_0040, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 601, 6, 1, 32'h0000_0050, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 602, 6, 1, 32'h0000_0060, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 603, 6, 1, 32'h0000_00A0, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 604, 6, 1, 32'h0000_00D0, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 605, 6, 1, 32'h0000_0100, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 605, 6, 1, 32'h0000_0110, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 606, 6, 1, 32'h0000_0200, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 607, 6, 1, 32'h0000_0210, 1'b1, 1'b1);
        enqueue_item(KIND_UNUSED, 0, 0, 0, 32'd0, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_START, 800, 6, 7, 32'h0000_0300, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_START, 800, 6, 2, 32'h0000_0300, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_STOP, 800, 6, 2, 32'h0000_0310, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_STOP, 800, 6, 2, 32'h0000_0320, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 2047, 20'hFFFFF, 6, 32'hFFFF_FFFF, 1'b0, 1'b0);
        enqueue_item(izs_pkg::KIND_TICK, 0, 20'hFFFFF, 6, 32'hFFFF_FFFF, 1'b0, 1'b1);
        wait_quiet();

        // Full table, start at midnight; the receiver holds off meanwhile.
        program_plan(4'd8, 11'd0, 8'($urandom_range(0, 3)), 11'($urandom_range(0, 2)),
                     short_durations(3), {$urandom(), $urandom()},
                     8'($urandom()), 1'b1);
        queue_run_traffic(100, 0);
        hold_requests++;
        wait_quiet();

        // Oversized zone count, largest repeat limit, no off-time, no pump.
        start_at = $urandom_range(0, 1439);
        program_plan(4'd15, 11'(start_at), 8'd255, 11'd0, short_durations(2),
                     56'hFF_FFFF_FFFF_FFFF, 8'($urandom()), 1'b0);
        queue_run_traffic(90, start_at);
        wait_quiet();

        // One zone of the longest duration, latest start, off-time of 1439 minutes.
        program_plan(4'd1, 11'd1439, 8'd1, 11'd1439, 64'hFFFF_FFFF_FFFF_FFFF,
                     56'hFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1);
        queue_run_traffic(60, 1439);
        wait_quiet();

        // Closing stretch without any idling on either side.
        idle_on  = 1'b0;
        start_at = $urandom_range(0, 1439);
        program_plan(4'($urandom_range(2, 7)), 11'(start_at), 8'($urandom_range(0, 2)),
                     11'($urandom_range(0, 1)), short_durations(2),
                     {$urandom(), $urandom()}, 8'($urandom()) | 8'd1,
                     1'($urandom_range(0, 1)));
        queue_run_traffic(120, start_at);
        wait_quiet();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hdl/izs_pkg.sv
hdl/izs_cfg_regs.sv
hdl/izs_step.sv
hdl/irrigation_zone_sequencer_unit.sv
hdl/izs_checker.sv
bench/irrigation_zone_sequencer_unit_test.sv
